@@ sv/bti_pkg.sv @@
package bti_pkg;

	localparam int CW    = 24;          // coordinate width
	localparam int VW    = 32;          // vertex value width
	localparam int WW    = 32;          // weight width, Q2.30
	localparam int WFRAC = 30;          // weight fraction bits
	localparam int DW    = CW + 1;      // coordinate difference
	localparam int PW    = 2 * DW;      // cross product term
	localparam int SW    = PW + 1;      // denominator and numerators
	localparam int NW    = SW + 2;      // third numerator
	localparam int MAG_W = NW;          // magnitudes in the divider
	localparam int QW    = WFRAC + 1;   // quotient bits below saturation
	localparam int MW    = WW + VW;     // weight times value
	localparam int AW    = MW + 2;      // sum of three products

	typedef struct packed {
		logic             neg;
		logic             sat;
		logic [MAG_W-1:0] rem;
		logic [QW-1:0]    quo;
	} lane_t;

	typedef struct packed {
		logic             degen;
		logic             in_tri;
		logic [MAG_W-1:0] den;
		lane_t [2:0]      lane;
		logic [2:0][VW-1:0] val;
	} div_t;

endpackage

@@ sv/bti_div_cell.sv @@
module bti_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  bti_pkg::div_t din,
	output logic          vld_out,
	output bti_pkg::div_t dout
);

	bti_pkg::div_t nxt;

	// one restoring quotient bit per lane
	always_comb begin
		logic [bti_pkg::MAG_W:0] t;
		logic                    ge;
		nxt = din;
		for (int k = 0; k < 3; k++) begin
			t  = {din.lane[k].rem, 1'b0};
			ge = t >= {1'b0, din.den};
			nxt.lane[k].rem = ge ? bti_pkg::MAG_W'(t - {1'b0, din.den})
			                     : bti_pkg::MAG_W'(t);
			nxt.lane[k].quo = {din.lane[k].quo[bti_pkg::QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else         vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

@@ sv/bti_setup.sv @@
module bti_setup (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             vld_in,
	input  logic signed [bti_pkg::CW-1:0]    ax,
	input  logic signed [bti_pkg::CW-1:0]    ay,
	input  logic signed [bti_pkg::CW-1:0]    bx,
	input  logic signed [bti_pkg::CW-1:0]    by,
	input  logic signed [bti_pkg::CW-1:0]    cx,
	input  logic signed [bti_pkg::CW-1:0]    cy,
	input  logic signed [bti_pkg::CW-1:0]    px,
	input  logic signed [bti_pkg::CW-1:0]    py,
	input  logic [2:0][bti_pkg::VW-1:0]      val,
	output logic                             vld_out,
	output bti_pkg::div_t                    dout
);

	logic [5:0] vld_q;
	logic signed [bti_pkg::DW-1:0] byc_s1, axc_s1, cxb_s1, ayc_s1, pxc_s1, pyc_s1, cya_s1;
	logic signed [bti_pkg::PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [bti_pkg::SW-1:0] d_s3, nu_s3, nv_s3;
	logic signed [bti_pkg::NW-1:0] d_s4, nu_s4, nv_s4, nw_s4;
	logic [bti_pkg::MAG_W-1:0] dmag_s5;
	logic [2:0][bti_pkg::MAG_W-1:0] mag_s5;
	logic [2:0] neg_s5;
	logic degen_s5, inside_s5;
	logic [2:0][bti_pkg::VW-1:0] val_s1, val_s2, val_s3, val_s4, val_s5;
	logic signed [bti_pkg::NW-1:0] n4 [3];
	logic d_pos, all_ge, all_le;

	// advance valid through the setup stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[4:0], vld_in};
	end
	assign vld_out = vld_q[5];

	// edge differences
	always_ff @(posedge clk) begin
		byc_s1 <= bti_pkg::DW'(by) - bti_pkg::DW'(cy);
		axc_s1 <= bti_pkg::DW'(ax) - bti_pkg::DW'(cx);
		cxb_s1 <= bti_pkg::DW'(cx) - bti_pkg::DW'(bx);
		ayc_s1 <= bti_pkg::DW'(ay) - bti_pkg::DW'(cy);
		pxc_s1 <= bti_pkg::DW'(px) - bti_pkg::DW'(cx);
		pyc_s1 <= bti_pkg::DW'(py) - bti_pkg::DW'(cy);
		cya_s1 <= bti_pkg::DW'(cy) - bti_pkg::DW'(ay);
		val_s1 <= val;
	end

	// cross products
	always_ff @(posedge clk) begin
		p0_s2  <= byc_s1 * axc_s1;
		p1_s2  <= cxb_s1 * ayc_s1;
		p2_s2  <= byc_s1 * pxc_s1;
		p3_s2  <= cxb_s1 * pyc_s1;
		p4_s2  <= cya_s1 * pxc_s1;
		p5_s2  <= axc_s1 * pyc_s1;
		val_s2 <= val_s1;
	end

	// denominator and first two numerators
	always_ff @(posedge clk) begin
		d_s3   <= bti_pkg::SW'(p0_s2) + bti_pkg::SW'(p1_s2);
		nu_s3  <= bti_pkg::SW'(p2_s2) + bti_pkg::SW'(p3_s2);
		nv_s3  <= bti_pkg::SW'(p4_s2) + bti_pkg::SW'(p5_s2);
		val_s3 <= val_s2;
	end

	// third numerator
	always_ff @(posedge clk) begin
		d_s4   <= bti_pkg::NW'(d_s3);
		nu_s4  <= bti_pkg::NW'(nu_s3);
		nv_s4  <= bti_pkg::NW'(nv_s3);
		nw_s4  <= bti_pkg::NW'(d_s3) - bti_pkg::NW'(nu_s3) - bti_pkg::NW'(nv_s3);
		val_s4 <= val_s3;
	end

	// containment test by signs
	always_comb begin
		n4[0]  = nu_s4;
		n4[1]  = nv_s4;
		n4[2]  = nw_s4;
		d_pos  = !d_s4[bti_pkg::NW-1] && (d_s4 != '0);
		all_ge = !nu_s4[bti_pkg::NW-1] && !nv_s4[bti_pkg::NW-1] && !nw_s4[bti_pkg::NW-1];
		all_le = (nu_s4[bti_pkg::NW-1] || nu_s4 == '0) &&
		         (nv_s4[bti_pkg::NW-1] || nv_s4 == '0) &&
		         (nw_s4[bti_pkg::NW-1] || nw_s4 == '0);
	end

	// magnitudes and quotient signs
	always_ff @(posedge clk) begin
		dmag_s5   <= d_s4[bti_pkg::NW-1] ? (~d_s4 + 1'b1) : d_s4;
		degen_s5  <= (d_s4 == '0);
		inside_s5 <= (d_s4 != '0) && (d_pos ? all_ge : all_le);
		for (int k = 0; k < 3; k++) begin
			mag_s5[k] <= n4[k][bti_pkg::NW-1] ? (~n4[k] + 1'b1) : n4[k];
			neg_s5[k] <= n4[k][bti_pkg::NW-1] ^ d_s4[bti_pkg::NW-1];
		end
		val_s5 <= val_s4;
	end

	// saturation check and integer quotient bit
	always_ff @(posedge clk) begin
		logic ge0;
		dout.degen  <= degen_s5;
		dout.in_tri <= inside_s5;
		dout.den    <= dmag_s5;
		dout.val    <= val_s5;
		for (int k = 0; k < 3; k++) begin
			ge0 = mag_s5[k] >= dmag_s5;
			dout.lane[k].neg <= neg_s5[k];
			dout.lane[k].sat <= {1'b0, mag_s5[k]} >= {dmag_s5, 1'b0};
			dout.lane[k].rem <= ge0 ? (mag_s5[k] - dmag_s5) : mag_s5[k];
			dout.lane[k].quo <= {{(bti_pkg::QW-1){1'b0}}, ge0};
		end
	end

endmodule

@@ sv/bti_finish.sv @@
module bti_finish (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_in,
	input  bti_pkg::div_t                 din,
	output logic                          done,
	output logic                          inside_res,
	output logic                          degenerate,
	output logic signed [bti_pkg::WW-1:0] weight_u,
	output logic signed [bti_pkg::WW-1:0] weight_v,
	output logic signed [bti_pkg::WW-1:0] weight_w,
	output logic signed [bti_pkg::VW-1:0] interpolated
);

	localparam logic signed [bti_pkg::WW-1:0] WMAX = {1'b0, {(bti_pkg::WW-1){1'b1}}};
	localparam logic signed [bti_pkg::WW-1:0] WMIN = {1'b1, {(bti_pkg::WW-1){1'b0}}};
	localparam logic signed [bti_pkg::AW-1:0] ROUND = bti_pkg::AW'((64'd1 << bti_pkg::WFRAC) - 64'd1);
	localparam int QTW = bti_pkg::AW - bti_pkg::WFRAC;
	localparam logic signed [QTW-1:0] VMAX = QTW'({1'b0, {(bti_pkg::VW-1){1'b1}}});
	localparam logic signed [QTW-1:0] VMIN = -VMAX - QTW'(1);

	logic [4:0] vld_q;
	logic signed [2:0][bti_pkg::WW-1:0] w_f1, w_f2, w_f3, w_f4;
	logic [2:0][bti_pkg::VW-1:0] val_f1;
	logic signed [bti_pkg::MW-1:0] m_f2 [3];
	logic signed [bti_pkg::AW-1:0] sum_f3, adj_f4;
	logic [3:0] ins_q, deg_q;
	logic signed [QTW-1:0] quot;

	// advance valid through the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[3:0], vld_in};
	end
	assign done = vld_q[4];

	// signed, saturated Q2.30 weights
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (din.degen)
				w_f1[k] <= '0;
			else if (din.lane[k].sat)
				w_f1[k] <= din.lane[k].neg ? WMIN : WMAX;
			else if (din.lane[k].neg)
				w_f1[k] <= -bti_pkg::WW'(din.lane[k].quo);
			else
				w_f1[k] <= bti_pkg::WW'(din.lane[k].quo);
		end
		val_f1   <= din.val;
		ins_q[0] <= din.in_tri;
		deg_q[0] <= din.degen;
	end

	// weight times vertex value
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			m_f2[k] <= $signed(w_f1[k]) * $signed(val_f1[k]);
		w_f2     <= w_f1;
		ins_q[1] <= ins_q[0];
		deg_q[1] <= deg_q[0];
	end

	// sum of the three terms
	always_ff @(posedge clk) begin
		sum_f3   <= bti_pkg::AW'(m_f2[0]) + bti_pkg::AW'(m_f2[1]) + bti_pkg::AW'(m_f2[2]);
		w_f3     <= w_f2;
		ins_q[2] <= ins_q[1];
		deg_q[2] <= deg_q[1];
	end

	// bias negative sums so the shift truncates toward zero
	always_ff @(posedge clk) begin
		adj_f4   <= sum_f3 + (sum_f3[bti_pkg::AW-1] ? ROUND : '0);
		w_f4     <= w_f3;
		ins_q[3] <= ins_q[2];
		deg_q[3] <= deg_q[2];
	end

	assign quot = adj_f4[bti_pkg::AW-1:bti_pkg::WFRAC];

	// saturate and drive the result
	always_ff @(posedge clk) begin
		weight_u   <= w_f4[0];
		weight_v   <= w_f4[1];
		weight_w   <= w_f4[2];
		inside_res <= ins_q[3];
		degenerate <= deg_q[3];
		if (!ins_q[3])
			interpolated <= '0;
		else if (quot > VMAX)
			interpolated <= VMAX[bti_pkg::VW-1:0];
		else if (quot < VMIN)
			interpolated <= VMIN[bti_pkg::VW-1:0];
		else
			interpolated <= quot[bti_pkg::VW-1:0];
	end

endmodule

@@ sv/barycentric_triangle_interpolator_top.sv @@
// Channel   | Signals                                              | Handshake
// ----------+------------------------------------------------------+----------------------
// command   | vertex_*_x/_y, vertex_*_value, point_x, point_y      | start high, busy low
// result    | inside_res, degenerate, weight_u/v/w, interpolated    | done, one cycle
//
// One transaction per cycle; busy stays low. Each result passes through
// 6 setup stages, 30 divider cells (one quotient bit each, three weights
// side by side) and 5 stages for weights and interpolation.
// arst_n clears only the valid bits. The receiver cannot stall the result.
module barycentric_triangle_interpolator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [bti_pkg::CW-1:0] vertex_a_x,
	input  logic signed [bti_pkg::CW-1:0] vertex_a_y,
	input  logic signed [bti_pkg::CW-1:0] vertex_b_x,
	input  logic signed [bti_pkg::CW-1:0] vertex_b_y,
	input  logic signed [bti_pkg::CW-1:0] vertex_c_x,
	input  logic signed [bti_pkg::CW-1:0] vertex_c_y,
	input  logic signed [bti_pkg::VW-1:0] vertex_a_value,
	input  logic signed [bti_pkg::VW-1:0] vertex_b_value,
	input  logic signed [bti_pkg::VW-1:0] vertex_c_value,
	input  logic signed [bti_pkg::CW-1:0] point_x,
	input  logic signed [bti_pkg::CW-1:0] point_y,
	output logic                          done,
	output logic                          inside_res,
	output logic                          degenerate,
	output logic signed [bti_pkg::WW-1:0] weight_u,
	output logic signed [bti_pkg::WW-1:0] weight_v,
	output logic signed [bti_pkg::WW-1:0] weight_w,
	output logic signed [bti_pkg::VW-1:0] interpolated
);

	localparam int NCELL = bti_pkg::WFRAC;

	bti_pkg::div_t chain [NCELL+1];
	logic          chain_vld [NCELL+1];
	logic [2:0][bti_pkg::VW-1:0] vals;

	// fully pipelined, never holds off a command
	assign busy = 1'b0;
	assign vals = {vertex_c_value, vertex_b_value, vertex_a_value};

	bti_setup u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (start),
		.ax      (vertex_a_x),
		.ay      (vertex_a_y),
		.bx      (vertex_b_x),
		.by      (vertex_b_y),
		.cx      (vertex_c_x),
		.cy      (vertex_c_y),
		.px      (point_x),
		.py      (point_y),
		.val     (vals),
		.vld_out (chain_vld[0]),
		.dout    (chain[0])
	);

	// row of quotient cells
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		bti_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (chain_vld[i]),
			.din     (chain[i]),
			.vld_out (chain_vld[i+1]),
			.dout    (chain[i+1])
		);
	end

	bti_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld_in       (chain_vld[NCELL]),
		.din          (chain[NCELL]),
		.done         (done),
		.inside_res   (inside_res),
		.degenerate   (degenerate),
		.weight_u     (weight_u),
		.weight_v     (weight_v),
		.weight_w     (weight_w),
		.interpolated (interpolated)
	);

endmodule
